// ===== hdl/lrcf_pkg.sv =====
// Shared types, constants and the pixel clip/address function for the line rasterizer.
// Used by lrcf_engine, lrcf_result_buf and line_rasterizer_with_corner_fill.
package lrcf_pkg;

  localparam int RowBytes = 160;
  localparam int XMax     = 319;
  localparam int YMax     = 199;
  localparam int MaxPix   = 3;

  localparam logic ACT_START = 1'b0;
  localparam logic ACT_STEP  = 1'b1;

  typedef logic signed [10:0] coord_t;
  typedef logic [11:0]        delta_t;
  typedef logic [12:0]        err_t;
  typedef logic [3:0]         color_t;

  typedef struct packed {
    logic        visible;
    logic [14:0] byte_offset;
    logic        low_nibble;
    color_t      pixel_color;
    logic        last_of_step;
    logic        line_done;
  } pix_t;

  typedef struct packed {
    logic [1:0]      count;
    pix_t [MaxPix-1:0] pix;
  } batch_t;

  // Clip one pixel to the screen and work out its byte and nibble.
  function automatic pix_t fmt_pixel(coord_t x, coord_t y, color_t c);
    pix_t p;
    logic vis;
    vis = !x[10] && !y[10] && (x[9:0] <= 10'(XMax)) && (y[9:0] <= 10'(YMax));
    p = '0;
    if (vis) begin
      p.visible     = 1'b1;
      p.byte_offset = 15'(y[7:0]) * 15'(RowBytes) + 15'(x[8:1]);
      p.low_nibble  = x[0];
      p.pixel_color = c;
    end
    return p;
  endfunction

endpackage

// ===== hdl/line_rasterizer_with_corner_fill.sv =====
// Line rasterizer top level: request channel, Bresenham engine and result buffer.
// Depends on lrcf_pkg, lrcf_engine and lrcf_result_buf.
//
// Usage:
//   Input channel (in_valid/in_ready) takes requests. action 0 loads a line
//   (endpoints, main and side color, smooth) and yields no pixel. action 1 steps
//   the line and yields one pixel, or three when smooth is set and the minor
//   axis moves before the endpoint (main pixel, then two corner-fill pixels).
//   Output channel (out_valid/out_ready) delivers one pixel per transfer, with
//   last_of_step on the final pixel of a step and line_done on the endpoint.
//   A step's first pixel appears in the cycle after the request is taken.
//   One request is taken per cycle for one-pixel steps while the receiver is
//   ready; a corner-fill step holds the input until the three-entry buffer drains.
//   A stalled receiver holds the buffer; in_ready drops until its last pixel
//   is taken (same cycle allowed). Reset clears the line (no line active) and
//   empties the buffer.
module line_rasterizer_with_corner_fill (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                action,
  input  logic signed [10:0]  x_start,
  input  logic signed [10:0]  y_start,
  input  logic signed [10:0]  x_end,
  input  logic signed [10:0]  y_end,
  input  logic [3:0]          main_color,
  input  logic [3:0]          side_color,
  input  logic                smooth,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                visible,
  output logic [14:0]         byte_offset,
  output logic                low_nibble,
  output logic [3:0]          pixel_color,
  output logic                last_of_step,
  output logic                line_done
);

  lrcf_pkg::batch_t batch;
  lrcf_pkg::pix_t   head;
  logic             take;
  logic             buf_free;

  assign in_ready = buf_free;
  assign take     = in_valid && in_ready;

  lrcf_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .action     (action),
    .x_start    (x_start),
    .y_start    (y_start),
    .x_end      (x_end),
    .y_end      (y_end),
    .main_color (main_color),
    .side_color (side_color),
    .smooth     (smooth),
    .batch      (batch)
  );

  lrcf_result_buf u_buf (
    .clk      (clk),
    .rst      (rst),
    .load     (take),
    .batch    (batch),
    .pop      (out_ready),
    .has_data (out_valid),
    .free     (buf_free),
    .head     (head)
  );

  assign visible      = head.visible;
  assign byte_offset  = head.byte_offset;
  assign low_nibble   = head.low_nibble;
  assign pixel_color  = head.pixel_color;
  assign last_of_step = head.last_of_step;
  assign line_done    = head.line_done;

  a_step_yields_pixel: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && action == lrcf_pkg::ACT_STEP |=> out_valid)
    else $error("step request produced no pixel");

  a_step_continues: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_of_step |=> out_valid && !in_ready || out_valid)
    else $error("pixels of a step lost before its last one");

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && line_done |-> last_of_step)
    else $error("line_done without last_of_step");

  a_clip_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !visible |-> byte_offset == 15'd0 && pixel_color == 4'd0 && !low_nibble)
    else $error("clipped pixel carries address or color");

endmodule

// ===== hdl/lrcf_engine.sv =====
// Bresenham line state and one-step pixel generation (main pixel plus corner fill).
// Depends on lrcf_pkg.
module lrcf_engine (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  logic                action,
  input  lrcf_pkg::coord_t    x_start,
  input  lrcf_pkg::coord_t    y_start,
  input  lrcf_pkg::coord_t    x_end,
  input  lrcf_pkg::coord_t    y_end,
  input  lrcf_pkg::color_t    main_color,
  input  lrcf_pkg::color_t    side_color,
  input  logic                smooth,
  output lrcf_pkg::batch_t    batch
);

  lrcf_pkg::coord_t cur_x, cur_y, end_x, end_y;
  lrcf_pkg::delta_t major_delta, minor_delta;
  lrcf_pkg::err_t   error_acc;
  logic [1:0]       step_signs;
  logic             x_is_major;
  logic             line_active;
  logic [7:0]       held_colors;
  logic             held_smooth;

  // start-item setup
  logic signed [11:0] dx, dy;
  lrcf_pkg::delta_t   adx, ady;
  logic               start_xmaj;

  // step-item evaluation
  lrcf_pkg::coord_t x_inc, y_inc;
  lrcf_pkg::coord_t cur_x_next, cur_y_next;
  lrcf_pkg::err_t   err_sum, err_next;
  logic             at_end, minor_move, corners;
  lrcf_pkg::color_t main_c, side_c;

  always_comb begin
    dx         = {x_end[10], x_end} - {x_start[10], x_start};
    dy         = {y_end[10], y_end} - {y_start[10], y_start};
    adx        = dx[11] ? 12'(-dx) : 12'(dx);
    ady        = dy[11] ? 12'(-dy) : 12'(dy);
    start_xmaj = ady < adx;
  end

  always_comb begin
    main_c     = held_colors[7:4];
    side_c     = held_colors[3:0];
    x_inc      = step_signs[0] ? cur_x - 11'sd1 : cur_x + 11'sd1;
    y_inc      = step_signs[1] ? cur_y - 11'sd1 : cur_y + 11'sd1;
    at_end     = x_is_major ? (cur_x == end_x) : (cur_y == end_y);
    err_sum    = error_acc + 13'(minor_delta);
    minor_move = err_sum > 13'(major_delta);
    err_next   = minor_move ? err_sum - 13'(major_delta) : err_sum;
    corners    = minor_move && held_smooth;

    if (x_is_major) begin
      cur_x_next = x_inc;
      cur_y_next = minor_move ? y_inc : cur_y;
    end else begin
      cur_x_next = minor_move ? x_inc : cur_x;
      cur_y_next = y_inc;
    end

    batch = '0;
    if (action == lrcf_pkg::ACT_STEP) begin
      batch.count = 2'd1;
      if (!line_active) begin
        batch.pix[0].last_of_step = 1'b1;
        batch.pix[0].line_done    = 1'b1;
      end else begin
        batch.pix[0] = lrcf_pkg::fmt_pixel(cur_x, cur_y, main_c);
        if (at_end) begin
          batch.pix[0].last_of_step = 1'b1;
          batch.pix[0].line_done    = 1'b1;
        end else if (corners) begin
          batch.count = 2'd3;
          // next major pixel on the old minor line, then current major on the new one
          if (x_is_major) begin
            batch.pix[1] = lrcf_pkg::fmt_pixel(x_inc, cur_y, side_c);
            batch.pix[2] = lrcf_pkg::fmt_pixel(cur_x, y_inc, side_c);
          end else begin
            batch.pix[1] = lrcf_pkg::fmt_pixel(cur_x, y_inc, side_c);
            batch.pix[2] = lrcf_pkg::fmt_pixel(x_inc, cur_y, side_c);
          end
          batch.pix[2].last_of_step = 1'b1;
        end else begin
          batch.pix[0].last_of_step = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x       <= '0;
      cur_y       <= '0;
      end_x       <= '0;
      end_y       <= '0;
      major_delta <= '0;
      minor_delta <= '0;
      error_acc   <= '0;
      step_signs  <= '0;
      x_is_major  <= 1'b0;
      line_active <= 1'b0;
      held_colors <= '0;
      held_smooth <= 1'b0;
    end else if (take) begin
      if (action == lrcf_pkg::ACT_START) begin
        cur_x       <= x_start;
        cur_y       <= y_start;
        end_x       <= x_end;
        end_y       <= y_end;
        step_signs  <= {dy[11], dx[11]};
        x_is_major  <= start_xmaj;
        major_delta <= start_xmaj ? adx : ady;
        minor_delta <= start_xmaj ? ady : adx;
        error_acc   <= 13'(start_xmaj ? adx[11:1] : ady[11:1]);
        held_colors <= {main_color, side_color};
        held_smooth <= smooth;
        line_active <= 1'b1;
      end else if (line_active) begin
        if (at_end) begin
          line_active <= 1'b0;
        end else begin
          cur_x     <= cur_x_next;
          cur_y     <= cur_y_next;
          error_acc <= err_next;
        end
      end
    end
  end

endmodule

// ===== hdl/lrcf_result_buf.sv =====
// Three-entry result register: loads one step's pixels at once and drains them in order.
// Depends on lrcf_pkg.
module lrcf_result_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  lrcf_pkg::batch_t  batch,
  input  logic              pop,
  output logic              has_data,
  output logic              free,
  output lrcf_pkg::pix_t    head
);

  lrcf_pkg::pix_t entry [lrcf_pkg::MaxPix];
  logic [1:0]     cnt;

  assign has_data = cnt != 2'd0;
  // room for a new batch once the last held pixel leaves this cycle
  assign free     = (cnt == 2'd0) || (cnt == 2'd1 && pop);
  assign head     = entry[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load && batch.count != 2'd0) begin
      cnt <= batch.count;
    end else if (pop && has_data) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load && batch.count != 2'd0) begin
      entry[0] <= batch.pix[0];
      entry[1] <= batch.pix[1];
      entry[2] <= batch.pix[2];
    end else if (pop && has_data) begin
      entry[0] <= entry[1];
      entry[1] <= entry[2];
    end
  end

endmodule

// ===== test/lrcf_pixel_checker.sv =====
// Pixel checker for the line rasterizer: watches both channels, predicts pixels, compares them.
// Depends on lrcf_pkg for the coordinate, color and pixel types and the screen constants.
`timescale 1ns / 100ps
module lrcf_pixel_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic              action,
  input  lrcf_pkg::coord_t  x_start,
  input  lrcf_pkg::coord_t  y_start,
  input  lrcf_pkg::coord_t  x_end,
  input  lrcf_pkg::coord_t  y_end,
  input  lrcf_pkg::color_t  main_color,
  input  lrcf_pkg::color_t  side_color,
  input  logic              smooth,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic              visible,
  input  logic [14:0]       byte_offset,
  input  logic              low_nibble,
  input  lrcf_pkg::color_t  pixel_color,
  input  logic              last_of_step,
  input  logic              line_done,
  output int                err_count,
  output int                pixels_pending,
  output int                pixels_checked
);

  lrcf_pkg::pix_t expected_pixels[$];

  // Line state as the engine should hold it.
  lrcf_pkg::coord_t pos_x, pos_y, stop_x, stop_y;
  lrcf_pkg::delta_t major_d, minor_d;
  lrcf_pkg::err_t   err_acc;
  logic             neg_x, neg_y, x_major, active, fill_on;
  lrcf_pkg::color_t line_color, fill_color;

  function automatic lrcf_pkg::pix_t screen_pixel(int x, int y, lrcf_pkg::color_t c);
    lrcf_pkg::pix_t p;
    p = '0;
    if (x >= 0 && y >= 0 && x <= lrcf_pkg::XMax && y <= lrcf_pkg::YMax) begin
      p.visible     = 1'b1;
      p.byte_offset = 15'(lrcf_pkg::RowBytes * y + x / 2);
      p.low_nibble  = x[0];
      p.pixel_color = c;
    end
    return p;
  endfunction

  task automatic predict_request();
    int             dx, dy, sx, sy, acc;
    logic           at_end;
    lrcf_pkg::pix_t p;
    if (action == lrcf_pkg::ACT_START) begin
      pos_x  = x_start;
      pos_y  = y_start;
      stop_x = x_end;
      stop_y = y_end;
      dx = int'(x_end) - int'(x_start);
      dy = int'(y_end) - int'(y_start);
      neg_x = (dx < 0);
      neg_y = (dy < 0);
      if (neg_x) dx = -dx;
      if (neg_y) dy = -dy;
      // equal deltas leave y as the major axis
      x_major = (dy < dx);
      major_d = lrcf_pkg::delta_t'(x_major ? dx : dy);
      minor_d = lrcf_pkg::delta_t'(x_major ? dy : dx);
      err_acc = lrcf_pkg::err_t'(major_d >> 1);
      line_color = main_color;
      fill_color = side_color;
      fill_on    = smooth;
      active     = 1'b1;
    end else if (!active) begin
      p = '0;
      p.last_of_step = 1'b1;
      p.line_done    = 1'b1;
      expected_pixels.push_back(p);
    end else begin
      sx = neg_x ? -1 : 1;
      sy = neg_y ? -1 : 1;
      at_end = x_major ? (pos_x == stop_x) : (pos_y == stop_y);
      p = screen_pixel(pos_x, pos_y, line_color);
      if (at_end) begin
        p.last_of_step = 1'b1;
        p.line_done    = 1'b1;
        expected_pixels.push_back(p);
        active = 1'b0;
      end else begin
        expected_pixels.push_back(p);
        acc = int'(err_acc) + int'(minor_d);
        if (acc > int'(major_d)) begin
          acc -= int'(major_d);
          // corner fill: next major pixel on the old minor row, then the new minor row
          if (x_major) begin
            if (fill_on)
              expected_pixels.push_back(screen_pixel(pos_x + sx, pos_y, fill_color));
            pos_y = lrcf_pkg::coord_t'(int'(pos_y) + sy);
          end else begin
            if (fill_on)
              expected_pixels.push_back(screen_pixel(pos_x, pos_y + sy, fill_color));
            pos_x = lrcf_pkg::coord_t'(int'(pos_x) + sx);
          end
          if (fill_on) expected_pixels.push_back(screen_pixel(pos_x, pos_y, fill_color));
        end
        err_acc = lrcf_pkg::err_t'(acc);
        if (x_major) pos_x = lrcf_pkg::coord_t'(int'(pos_x) + sx);
        else         pos_y = lrcf_pkg::coord_t'(int'(pos_y) + sy);
        p = expected_pixels[expected_pixels.size() - 1];
        p.last_of_step = 1'b1;
        expected_pixels[expected_pixels.size() - 1] = p;
      end
    end
  endtask

  task automatic compare_pixel();
    lrcf_pkg::pix_t want, got;
    got = {visible, byte_offset, low_nibble, pixel_color, last_of_step, line_done};
    if (expected_pixels.size() == 0) begin
      err_count++;
      if (err_count <= 10)
        $display("%0t: pixel with none expected: vis=%0d off=%0d low=%0d col=%0d %s%0d %s%0d",
                 $time, got.visible, got.byte_offset, got.low_nibble, got.pixel_color,
                 "last=", got.last_of_step, "done=", got.line_done);
    end else begin
      want = expected_pixels.pop_front();
      pixels_checked++;
      if (got.visible !== want.visible || got.byte_offset !== want.byte_offset ||
          got.low_nibble !== want.low_nibble || got.pixel_color !== want.pixel_color ||
          got.last_of_step !== want.last_of_step || got.line_done !== want.line_done) begin
        err_count++;
        if (err_count <= 10) begin
          $display("%0t: pixel mismatch: expected vis=%0d off=%0d low=%0d col=%0d %s%0d %s%0d",
                   $time, want.visible, want.byte_offset, want.low_nibble, want.pixel_color,
                   "last=", want.last_of_step, "done=", want.line_done);
          $display("    got vis=%0d off=%0d low=%0d col=%0d last=%0d done=%0d",
                   got.visible, got.byte_offset, got.low_nibble, got.pixel_color,
                   got.last_of_step, got.line_done);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pos_x = '0; pos_y = '0; stop_x = '0; stop_y = '0;
      major_d = '0; minor_d = '0; err_acc = '0;
      neg_x = 1'b0; neg_y = 1'b0; x_major = 1'b0; active = 1'b0; fill_on = 1'b0;
      line_color = '0; fill_color = '0;
      expected_pixels.delete();
      err_count = 0;
      pixels_checked = 0;
    end else begin
      // take the outgoing pixel first: a request accepted now has no pixel out yet
      if (out_valid && out_ready) compare_pixel();
      if (in_valid && in_ready) predict_request();
    end
    pixels_pending = expected_pixels.size();
  end

endmodule

// ===== test/line_rasterizer_with_corner_fill_tb.sv =====
// Testbench top for the line rasterizer: clock, reset, request and pixel channel drivers, verdict.
// Depends on lrcf_pkg, line_rasterizer_with_corner_fill and lrcf_pixel_checker.
`timescale 1ns / 100ps
module line_rasterizer_with_corner_fill_tb;

  localparam int HoldCycles = 300;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              action = lrcf_pkg::ACT_START;
  lrcf_pkg::coord_t  x_start = '0;
  lrcf_pkg::coord_t  y_start = '0;
  lrcf_pkg::coord_t  x_end = '0;
  lrcf_pkg::coord_t  y_end = '0;
  lrcf_pkg::color_t  main_color = '0;
  lrcf_pkg::color_t  side_color = '0;
  logic              smooth = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              visible;
  logic [14:0]       byte_offset;
  logic              low_nibble;
  lrcf_pkg::color_t  pixel_color;
  logic              last_of_step;
  logic              line_done;

  int err_count, pixels_pending, pixels_checked;
  int requests_sent = 0;
  int steps_sent = 0;
  int gap_pct = 0;
  int stall_pct = 0;
  int hold_seq = 0;
  int hold_done = 0;
  int hold_left = 0;

  line_rasterizer_with_corner_fill uut (.*);
  lrcf_pixel_checker checker_i (.*);

  always #4 clk = ~clk;

  // Pixel receiver: random stalls, plus a long hold whenever one is asked for.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_seq != hold_done) begin
      out_ready <= 1'b0;
      hold_left <= HoldCycles;
      hold_done <= hold_seq;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d pixels outstanding", pixels_pending);
    $display("line_rasterizer_with_corner_fill_tb: FAIL");
    $finish;
  end

  function automatic int clamp11(int v);
    return (v < -1024) ? -1024 : (v > 1023) ? 1023 : v;
  endfunction

  task automatic send_request(logic act, lrcf_pkg::coord_t xs, lrcf_pkg::coord_t ys,
                              lrcf_pkg::coord_t xe, lrcf_pkg::coord_t ye,
                              lrcf_pkg::color_t mc, lrcf_pkg::color_t sc, logic sm);
    @(negedge clk);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    action     <= act;
    x_start    <= xs;
    y_start    <= ys;
    x_end      <= xe;
    y_end      <= ye;
    main_color <= mc;
    side_color <= sc;
    smooth     <= sm;
    in_valid   <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    requests_sent++;
    if (act == lrcf_pkg::ACT_STEP) steps_sent++;
  endtask

  // Step fields are ignored by the block; fill them with noise.
  task automatic step_line();
    send_request(lrcf_pkg::ACT_STEP,
                 lrcf_pkg::coord_t'($urandom), lrcf_pkg::coord_t'($urandom),
                 lrcf_pkg::coord_t'($urandom), lrcf_pkg::coord_t'($urandom),
                 lrcf_pkg::color_t'($urandom), lrcf_pkg::color_t'($urandom), 1'($urandom));
  endtask

  task automatic draw_line(int xs, int ys, int xe, int ye, lrcf_pkg::color_t mc,
                           lrcf_pkg::color_t sc, logic sm, int steps);
    send_request(lrcf_pkg::ACT_START, lrcf_pkg::coord_t'(xs), lrcf_pkg::coord_t'(ys),
                 lrcf_pkg::coord_t'(xe), lrcf_pkg::coord_t'(ye), mc, sc, sm);
    repeat (steps) step_line();
  endtask

  // Mostly short lines near the screen run to their end; some are abandoned or overrun.
  task automatic random_line();
    int               xs, ys, xe, ye, span, dy_abs, steps;
    lrcf_pkg::coord_t c;
    if ($urandom_range(9) == 0) begin
      c = lrcf_pkg::coord_t'($urandom); xs = c;
      c = lrcf_pkg::coord_t'($urandom); ys = c;
      c = lrcf_pkg::coord_t'($urandom); xe = c;
      c = lrcf_pkg::coord_t'($urandom); ye = c;
      steps = $urandom_range(3);
    end else begin
      if ($urandom_range(4) == 0) begin
        c = lrcf_pkg::coord_t'($urandom); xs = c;
        c = lrcf_pkg::coord_t'($urandom); ys = c;
      end else begin
        xs = int'($urandom_range(360)) - 20;
        ys = int'($urandom_range(240)) - 20;
      end
      xe = clamp11(xs + int'($urandom_range(24)) - 12);
      ye = clamp11(ys + int'($urandom_range(24)) - 12);
      span   = (xe > xs) ? xe - xs : xs - xe;
      dy_abs = (ye > ys) ? ye - ys : ys - ye;
      if (dy_abs > span) span = dy_abs;
      case ($urandom_range(9))
        0:       steps = $urandom_range(span);
        1:       steps = span + 2;
        default: steps = span + 1;
      endcase
    end
    draw_line(xs, ys, xe, ye, lrcf_pkg::color_t'($urandom), lrcf_pkg::color_t'($urandom),
              ($urandom_range(3) != 0), steps);
  endtask

  initial begin
    int target;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // step before any line is loaded
    step_line();
    // x-major with corner fill, one step past the endpoint
    draw_line(0, 0, 4, 2, 4'hF, 4'h5, 1'b1, 6);
    // y-major, both axes stepping down, from the bottom-right corner
    draw_line(319, 199, 316, 195, 4'h0, 4'hF, 1'b1, 5);
    // single-point lines at the coordinate extremes, off screen
    draw_line(-1024, -1024, -1024, -1024, 4'hF, 4'hF, 1'b1, 1);
    draw_line(1023, 1023, 1023, 1023, 4'h0, 4'h0, 1'b0, 1);
    // diagonal tie, leaving the screen at the right and bottom edges
    draw_line(318, 198, 320, 200, 4'hA, 4'h3, 1'b1, 3);
    // no corner fill, abandoned by the next start
    draw_line(-3, 100, 9, 104, 4'h7, 4'h8, 1'b0, 3);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin gap_pct = 0;  stall_pct = 0;  end
        1:       begin gap_pct = 57; stall_pct = 0;  end
        2:       begin gap_pct = 0;  stall_pct = 57; end
        default: begin gap_pct = 10; stall_pct = 10; end
      endcase
      // hold the receiver off while requests keep coming, to back up the block
      if (ph == 0) hold_seq++;
      target = requests_sent + 68;
      while (requests_sent < target) random_line();
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pixels_pending != 0) @(negedge clk);
    repeat (16) @(negedge clk);

    $display("covered %0d requests (%0d steps) and %0d pixels over four gap/stall mixes",
             requests_sent, steps_sent, pixels_checked);
    $display("including a %0d-cycle output hold; %0d errors", HoldCycles, err_count);
    if (err_count == 0)
      $display("line_rasterizer_with_corner_fill_tb: PASS");
    else
      $display("line_rasterizer_with_corner_fill_tb: FAIL");
    $finish;
  end

endmodule
